FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the effective address unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eau assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eau assertion failed");

`endif

FILE: rtl/eau_pkg.sv
// Types, codes and helper functions of the effective address unit.
package eau_pkg;

	typedef logic [31:0] word_t;

	// Item actions
	typedef enum logic [1:0] {
		ACT_EA      = 2'd0,
		ACT_WR_AREG = 2'd1,
		ACT_WR_DREG = 2'd2,
		ACT_SET_PC  = 2'd3
	} action_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_MEMORY   = 2'd0,
		ST_REGISTER = 2'd1,
		ST_ADDR_ERR = 2'd2,
		ST_WRITTEN  = 2'd3
	} status_t;

	// Addressing modes
	localparam logic [2:0] MODE_DREG    = 3'd0;
	localparam logic [2:0] MODE_AREG    = 3'd1;
	localparam logic [2:0] MODE_IND     = 3'd2;
	localparam logic [2:0] MODE_POSTINC = 3'd3;
	localparam logic [2:0] MODE_PREDEC  = 3'd4;
	localparam logic [2:0] MODE_DISP    = 3'd5;
	localparam logic [2:0] MODE_INDEX   = 3'd6;
	localparam logic [2:0] MODE_EXT     = 3'd7;

	// Mode 7 sub-forms
	localparam logic [2:0] EXT_ABS_W    = 3'd0;
	localparam logic [2:0] EXT_ABS_L    = 3'd1;
	localparam logic [2:0] EXT_PC_DISP  = 3'd2;
	localparam logic [2:0] EXT_PC_INDEX = 3'd3;
	localparam logic [2:0] EXT_IMM      = 3'd4;

	// Operand sizes
	localparam logic [2:0] SIZE_BYTE = 3'd1;
	localparam logic [2:0] SIZE_WORD = 3'd2;
	localparam logic [2:0] SIZE_LONG = 3'd4;

	// Stack pointer register number
	localparam logic [2:0] SP_REG = 3'd7;

	// Brief extension word fields
	localparam word_t IDX_AREG_MASK = 32'h0000_8000;
	localparam word_t IDX_LONG_MASK = 32'h0000_0800;
	localparam word_t ALL_ONES      = 32'hFFFF_FFFF;

	function automatic word_t sext16(input word_t v);
		return {{16{v[15]}}, v[15:0]};
	endfunction

	function automatic word_t sext8(input word_t v);
		return {{24{v[7]}}, v[7:0]};
	endfunction

	function automatic word_t size_mask(input logic [2:0] size);
		word_t m;
		case (size)
			SIZE_BYTE: m = 32'h0000_00FF;
			SIZE_WORD: m = 32'h0000_FFFF;
			default:   m = ALL_ONES;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] step_of(input logic [2:0] size);
		logic [2:0] s;
		case (size)
			SIZE_BYTE, SIZE_WORD, SIZE_LONG: s = size;
			default:                         s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/eau_req_if.sv
// Request channel of the effective address unit: valid, ready and one operand item.
interface eau_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  mode;
	logic [2:0]  reg_field;
	logic [2:0]  size_bytes;
	logic [31:0] extension;
	logic [31:0] write_value;

	modport source (
		output valid, action, mode, reg_field, size_bytes, extension, write_value,
		input  ready
	);
	modport sink (
		input  valid, action, mode, reg_field, size_bytes, extension, write_value,
		output ready
	);
endinterface

FILE: rtl/eau_rsp_if.sv
// Response channel of the effective address unit: valid, ready and one result item.
interface eau_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] ea_value;
	logic [31:0] pc_after;
	logic [1:0]  ext_words_used;

	modport source (
		output valid, status, ea_value, pc_after, ext_words_used,
		input  ready
	);
	modport sink (
		input  valid, status, ea_value, pc_after, ext_words_used,
		output ready
	);
endinterface

FILE: rtl/effective_address_unit_core.sv
// Top level of the effective address unit: register file, PC and address computation.
// The eight data and eight address registers live in one 16-entry register file with two
// registered read ports and one write port; the program counter is a flip-flop that resets
// to zero. In the cycle an item is accepted on req, the base register
// (or the data register for register direct) and the index register named by the brief
// extension word are read; in the next cycle the address is formed, postincrement,
// predecrement and register writes go back into the file, and the result beat is loaded into
// the output register. A new item is taken only while the unit is idle and the result register
// is free or is being drained in the same cycle; no new item is taken while the previous one is
// being computed and written back. Data and address registers hold no defined value until written.
module effective_address_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	eau_req_if.sink    req,
	eau_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CALC = 2'b10
	} state_t;

	state_t                   state_q;
	logic                     out_valid_q;
	eau_pkg::status_t         status_q;
	eau_pkg::word_t           result_q;
	eau_pkg::word_t           pc_after_q;
	logic [1:0]               words_q;
	eau_pkg::word_t           pc_q;

	// Register file: entries 0..7 data, 8..15 address
	eau_pkg::word_t           regfile [16];
	logic [3:0]               rd_addr_a;
	logic [3:0]               rd_addr_b;
	eau_pkg::word_t           rd_a_q;
	eau_pkg::word_t           rd_b_q;
	logic                     wr_en;
	logic [3:0]               wr_addr;
	eau_pkg::word_t           wr_data;

	// Captured item
	eau_pkg::action_t         action_s1;
	logic [2:0]               mode_s1;
	logic [2:0]               reg_s1;
	logic [2:0]               size_s1;
	eau_pkg::word_t           ext_s1;
	eau_pkg::word_t           wval_s1;

	logic                     accept;
	eau_pkg::status_t         status_d;
	eau_pkg::word_t           result_d;
	eau_pkg::word_t           pc_d;
	logic [1:0]               words_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);

	// Read addresses come straight from the incoming beat
	assign rd_addr_a = {req.mode != eau_pkg::MODE_DREG, req.reg_field};
	assign rd_addr_b = {req.extension[15], req.extension[14:12]};

	// Register file with registered reads
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_q <= regfile[rd_addr_a];
			rd_b_q <= regfile[rd_addr_b];
		end
		if (wr_en) begin
			regfile[wr_addr] <= wr_data;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= eau_pkg::action_t'(req.action);
			mode_s1   <= req.mode;
			reg_s1    <= req.reg_field;
			size_s1   <= req.size_bytes;
			ext_s1    <= req.extension;
			wval_s1   <= req.write_value;
		end
	end

	// Address computation and write-back selection
	always_comb begin
		logic [2:0]     step;
		eau_pkg::word_t inc;
		logic           fetch;
		eau_pkg::word_t idx_val;
		eau_pkg::word_t idx_base;
		eau_pkg::word_t idx_addr;
		eau_pkg::word_t adj;

		step     = eau_pkg::step_of(size_s1);
		inc      = ((reg_s1 == eau_pkg::SP_REG) && (size_s1 == eau_pkg::SIZE_BYTE))
			? 32'd2 : {29'd0, step};
		fetch    = (mode_s1 == eau_pkg::MODE_DISP) || (mode_s1 == eau_pkg::MODE_INDEX) ||
			((mode_s1 == eau_pkg::MODE_EXT) && (reg_s1 <= eau_pkg::EXT_PC_INDEX));
		idx_val  = ((ext_s1 & eau_pkg::IDX_LONG_MASK) != '0) ? rd_b_q : eau_pkg::sext16(rd_b_q);
		idx_base = (mode_s1 == eau_pkg::MODE_INDEX) ? rd_a_q : pc_q;
		idx_addr = idx_base + idx_val + eau_pkg::sext8(ext_s1);
		adj      = rd_a_q - inc;

		status_d = eau_pkg::ST_MEMORY;
		result_d = '0;
		pc_d     = pc_q;
		words_d  = 2'd0;
		wr_en    = 1'b0;
		wr_addr  = {1'b1, reg_s1};
		wr_data  = wval_s1;

		case (action_s1)
			eau_pkg::ACT_WR_AREG: begin
				wr_en    = (state_q == S_CALC);
				wr_addr  = {1'b1, reg_s1};
				status_d = eau_pkg::ST_WRITTEN;
				result_d = wval_s1;
			end
			eau_pkg::ACT_WR_DREG: begin
				wr_en    = (state_q == S_CALC);
				wr_addr  = {1'b0, reg_s1};
				status_d = eau_pkg::ST_WRITTEN;
				result_d = wval_s1;
			end
			eau_pkg::ACT_SET_PC: begin
				pc_d     = wval_s1;
				status_d = eau_pkg::ST_WRITTEN;
				result_d = wval_s1;
			end
			default: begin
				if ((mode_s1 == eau_pkg::MODE_DREG) || (mode_s1 == eau_pkg::MODE_AREG)) begin
					status_d = eau_pkg::ST_REGISTER;
					result_d = rd_a_q & eau_pkg::size_mask(size_s1);
				end else if (fetch && pc_q[0]) begin
					// Extension fetch from an odd PC
					status_d = eau_pkg::ST_ADDR_ERR;
					result_d = pc_q;
				end else begin
					case (mode_s1)
						eau_pkg::MODE_IND: begin
							result_d = rd_a_q;
						end
						eau_pkg::MODE_POSTINC: begin
							result_d = rd_a_q;
							wr_en    = (state_q == S_CALC);
							wr_data  = rd_a_q + inc;
						end
						eau_pkg::MODE_PREDEC: begin
							result_d = adj;
							wr_en    = (state_q == S_CALC);
							wr_data  = adj;
						end
						eau_pkg::MODE_DISP: begin
							result_d = rd_a_q + eau_pkg::sext16(ext_s1);
							words_d  = 2'd1;
						end
						eau_pkg::MODE_INDEX: begin
							result_d = idx_addr;
							words_d  = 2'd1;
						end
						eau_pkg::MODE_EXT: begin
							case (reg_s1)
								eau_pkg::EXT_ABS_W: begin
									result_d = eau_pkg::sext16(ext_s1);
									words_d  = 2'd1;
								end
								eau_pkg::EXT_ABS_L: begin
									result_d = ext_s1;
									words_d  = 2'd2;
								end
								eau_pkg::EXT_PC_DISP: begin
									result_d = pc_q + eau_pkg::sext16(ext_s1);
									words_d  = 2'd1;
								end
								eau_pkg::EXT_PC_INDEX: begin
									result_d = idx_addr;
									words_d  = 2'd1;
								end
								eau_pkg::EXT_IMM: begin
									// Byte immediate sits in the low half of a word
									if (size_s1 == eau_pkg::SIZE_BYTE) begin
										result_d = pc_q + 32'd1;
										pc_d     = pc_q + 32'd2;
										words_d  = 2'd1;
									end else begin
										result_d = pc_q;
										pc_d     = pc_q + {29'd0, step};
										words_d  = step[2:1];
									end
								end
								default: begin
									result_d = rd_a_q;
								end
							endcase
						end
						default: begin
							result_d = '0;
						end
					endcase
					if (fetch) begin
						pc_d = pc_q + {29'd0, words_d, 1'b0};
					end
				end
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && rsp.ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					out_valid_q <= 1'b1;
					pc_q        <= pc_d;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			status_q   <= status_d;
			result_q   <= result_d;
			pc_after_q <= pc_d;
			words_q    <= words_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.ea_value       = result_q;
	assign rsp.pc_after       = pc_after_q;
	assign rsp.ext_words_used = words_q;

endmodule

FILE: rtl/eau_checker.sv
// Port-level checker for the effective address unit and its bind to the top level.
`include "assert_macros.svh"

module eau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_ea_value,
	input logic [31:0] rsp_pc_after,
	input logic [1:0]  rsp_ext_words_used
);

	logic req_beat;
	logic rsp_stall;
	logic err_beat;
	logic err_ok;

	assign req_beat  = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign err_beat  = rsp_valid && (rsp_status == eau_pkg::ST_ADDR_ERR);
	assign err_ok    = (rsp_ea_value == rsp_pc_after) && rsp_pc_after[0] &&
		(rsp_ext_words_used == 2'd0);

	// A stalled result beat holds
	`EAU_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_ea_value))

	// Result register is empty while an accepted item is being worked on
	`EAU_ASSERT_NXT(a_busy_empty, req_beat, !rsp_valid)

	// Every accepted item shows its result beat once its compute state has passed
	`EAU_ASSERT_NXT(a_result_due, req_beat, ##1 rsp_valid)

	// No new item while a result waits and is not taken
	`EAU_ASSERT_IMP(a_no_overrun, rsp_stall, !req_ready)

	// An address error reports the unchanged odd PC and consumes nothing
	`EAU_ASSERT_IMP(a_addr_err, err_beat, err_ok)

endmodule

bind effective_address_unit_core eau_checker u_eau_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_ea_value       (rsp.ea_value),
	.rsp_pc_after       (rsp.pc_after),
	.rsp_ext_words_used (rsp.ext_words_used)
);

FILE: verif/tb.sv
// Self-checking testbench of effective_address_unit_core: directed and random operands.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS   = 600;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;

	// One operand or register write as queued for the request channel
	typedef struct {
		eau_pkg::action_t act;
		logic [2:0]       mode;
		logic [2:0]       rf;
		logic [2:0]       sz;
		eau_pkg::word_t   ext;
		eau_pkg::word_t   wval;
		bit               hold;	// wait until every outstanding result is back
	} eau_op_t;

	// One expected result beat
	typedef struct {
		eau_pkg::status_t st;
		eau_pkg::word_t   val;
		eau_pkg::word_t   pc;
		logic [1:0]       words;
	} eau_result_t;

	logic clk;
	logic arst_n;

	eau_req_if req_ch ();
	eau_rsp_if rsp_ch ();

	effective_address_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	eau_op_t     operand_queue [$];
	eau_result_t ea_results_due [$];

	// Shadow of the unit's architectural state
	eau_pkg::word_t areg [8];
	eau_pkg::word_t dreg [8];
	eau_pkg::word_t prog_ctr;

	// Registers written so far, seen from the stimulus side
	bit [7:0] a_set;
	bit [7:0] d_set;

	int total_ops;
	int ops_accepted;
	int results_seen;
	int n_errors;
	int n_mem, n_regop, n_aerr, n_wr;
	int quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Index term of a brief extension word plus base and 8-bit displacement
	function automatic eau_pkg::word_t brief_index_ea(input eau_pkg::word_t base,
		input eau_pkg::word_t ext);
		eau_pkg::word_t xv;
		xv = ((ext & eau_pkg::IDX_AREG_MASK) != 0) ? areg[ext[14:12]] : dreg[ext[14:12]];
		if ((ext & eau_pkg::IDX_LONG_MASK) == 0)
			xv = {{16{xv[15]}}, xv[15:0]};
		return base + xv + {{24{ext[7]}}, ext[7:0]};
	endfunction

	// Expected result of one accepted beat; updates the shadow state
	function automatic eau_result_t compute_ea(input eau_op_t op);
		eau_result_t    r;
		eau_pkg::word_t pc0, addr, v, d16;
		logic [2:0]     stp, bstep;
		logic [1:0]     words;
		bit             fetch;
		pc0   = prog_ctr;
		addr  = '0;
		words = 2'd0;
		d16   = {{16{op.ext[15]}}, op.ext[15:0]};
		case (op.act)
			eau_pkg::ACT_WR_AREG: begin
				areg[op.rf] = op.wval;
				r = '{eau_pkg::ST_WRITTEN, op.wval, prog_ctr, 2'd0};
			end
			eau_pkg::ACT_WR_DREG: begin
				dreg[op.rf] = op.wval;
				r = '{eau_pkg::ST_WRITTEN, op.wval, prog_ctr, 2'd0};
			end
			eau_pkg::ACT_SET_PC: begin
				prog_ctr = op.wval;
				r = '{eau_pkg::ST_WRITTEN, op.wval, prog_ctr, 2'd0};
			end
			default: begin
				if (op.mode == eau_pkg::MODE_DREG || op.mode == eau_pkg::MODE_AREG) begin
					v = (op.mode == eau_pkg::MODE_DREG) ? dreg[op.rf] : areg[op.rf];
					if (op.sz == eau_pkg::SIZE_BYTE)
						v = v & 32'h0000_00FF;
					else if (op.sz == eau_pkg::SIZE_WORD)
						v = v & 32'h0000_FFFF;
					r = '{eau_pkg::ST_REGISTER, v, pc0, 2'd0};
				end else begin
					fetch = (op.mode == eau_pkg::MODE_DISP) || (op.mode == eau_pkg::MODE_INDEX) ||
						(op.mode == eau_pkg::MODE_EXT && op.rf <= eau_pkg::EXT_PC_INDEX);
					if (fetch && pc0[0]) begin
						r = '{eau_pkg::ST_ADDR_ERR, pc0, pc0, 2'd0};
					end else begin
						stp = (op.sz == eau_pkg::SIZE_BYTE || op.sz == eau_pkg::SIZE_WORD ||
							op.sz == eau_pkg::SIZE_LONG) ? op.sz : 3'd0;
						// byte on the stack pointer keeps it word aligned
						bstep = (op.rf == eau_pkg::SP_REG && op.sz == eau_pkg::SIZE_BYTE) ?
							3'd2 : stp;
						case (op.mode)
							eau_pkg::MODE_IND: addr = areg[op.rf];
							eau_pkg::MODE_POSTINC: begin
								addr = areg[op.rf];
								areg[op.rf] = areg[op.rf] + {29'd0, bstep};
							end
							eau_pkg::MODE_PREDEC: begin
								areg[op.rf] = areg[op.rf] - {29'd0, bstep};
								addr = areg[op.rf];
							end
							eau_pkg::MODE_DISP: begin
								addr  = areg[op.rf] + d16;
								words = 2'd1;
							end
							eau_pkg::MODE_INDEX: begin
								addr  = brief_index_ea(areg[op.rf], op.ext);
								words = 2'd1;
							end
							default: begin
								case (op.rf)
									eau_pkg::EXT_ABS_W: begin
										addr  = d16;
										words = 2'd1;
									end
									eau_pkg::EXT_ABS_L: begin
										addr  = op.ext;
										words = 2'd2;
									end
									eau_pkg::EXT_PC_DISP: begin
										addr  = pc0 + d16;
										words = 2'd1;
									end
									eau_pkg::EXT_PC_INDEX: begin
										addr  = brief_index_ea(pc0, op.ext);
										words = 2'd1;
									end
									eau_pkg::EXT_IMM: begin
										// byte immediate sits in the low half of its word
										if (op.sz == eau_pkg::SIZE_BYTE) begin
											addr     = pc0 + 32'd1;
											prog_ctr = pc0 + 32'd2;
											words    = 2'd1;
										end else begin
											addr     = pc0;
											prog_ctr = pc0 + {29'd0, stp};
											words    = stp[2:1];
										end
									end
									default: addr = areg[op.rf];
								endcase
							end
						endcase
						if (fetch)
							prog_ctr = pc0 + {29'd0, words, 1'b0};
						r = '{eau_pkg::ST_MEMORY, addr, prog_ctr, words};
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic eau_op_t mk_op(input eau_pkg::action_t act, input logic [2:0] mode,
		input logic [2:0] rf, input logic [2:0] sz, input eau_pkg::word_t ext,
		input eau_pkg::word_t wval);
		eau_op_t op;
		op = '{act, mode, rf, sz, ext, wval, 1'b0};
		return op;
	endfunction

	// Load a register with a random value unless it already holds one
	task automatic need_reg(input bit is_areg, input logic [2:0] rf);
		eau_op_t w;
		if (is_areg ? !a_set[rf] : !d_set[rf]) begin
			w = mk_op(is_areg ? eau_pkg::ACT_WR_AREG : eau_pkg::ACT_WR_DREG,
				3'($urandom_range(0, 7)), rf, 3'($urandom_range(0, 7)), $urandom, $urandom);
			operand_queue.push_back(w);
			if (is_areg)
				a_set[rf] = 1'b1;
			else
				d_set[rf] = 1'b1;
		end
	endtask

	// Queue an operation, preceded by writes of any register it would read unset
	task automatic queue_op(input eau_op_t op);
		if (op.act == eau_pkg::ACT_EA) begin
			if (op.mode == eau_pkg::MODE_DREG)
				need_reg(1'b0, op.rf);
			else if (op.mode != eau_pkg::MODE_EXT || op.rf > eau_pkg::EXT_IMM)
				need_reg(1'b1, op.rf);
			if (op.mode == eau_pkg::MODE_INDEX ||
				(op.mode == eau_pkg::MODE_EXT && op.rf == eau_pkg::EXT_PC_INDEX))
				need_reg(op.ext[15], op.ext[14:12]);
		end else if (op.act == eau_pkg::ACT_WR_AREG) begin
			a_set[op.rf] = 1'b1;
		end else if (op.act == eau_pkg::ACT_WR_DREG) begin
			d_set[op.rf] = 1'b1;
		end
		operand_queue.push_back(op);
	endtask

	function automatic eau_pkg::word_t corner_word();
		eau_pkg::word_t w;
		case ($urandom_range(0, 5))
			0: w = 32'h0000_0000;
			1: w = eau_pkg::ALL_ONES;
			2: w = 32'h0000_8000;
			3: w = 32'h0000_7FFF;
			4: w = 32'h0000_FFFF;
			default: w = 32'h8000_0000;
		endcase
		return w;
	endfunction

	function automatic eau_op_t rand_op();
		eau_op_t op;
		int      k;
		k       = $urandom_range(0, 99);
		op.act  = (k < 10) ? eau_pkg::ACT_WR_AREG : (k < 18) ? eau_pkg::ACT_WR_DREG :
			(k < 24) ? eau_pkg::ACT_SET_PC : eau_pkg::ACT_EA;
		op.mode = 3'($urandom_range(0, 7));
		op.rf   = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: op.sz = eau_pkg::SIZE_BYTE;
			1: op.sz = eau_pkg::SIZE_WORD;
			2: op.sz = eau_pkg::SIZE_LONG;
			default: op.sz = 3'($urandom_range(0, 7));
		endcase
		op.ext  = ($urandom_range(0, 99) < 20) ? corner_word() : $urandom;
		op.wval = ($urandom_range(0, 99) < 15) ? corner_word() : $urandom;
		// mostly even program counters so fetches get through
		if (op.act == eau_pkg::ACT_SET_PC && $urandom_range(0, 99) < 70)
			op.wval[0] = 1'b0;
		op.hold = 1'b0;
		return op;
	endfunction

	function automatic int sender_idle_pct();
		if (ops_accepted < total_ops / 3)
			return 28;
		else if (ops_accepted < 2 * total_ops / 3)
			return 86;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (ops_accepted < total_ops / 3)
			return 86;
		else if (ops_accepted < 2 * total_ops / 3)
			return 28;
		return 0;
	endfunction

	// Request driver: predicts each accepted beat, then presents the next one
	always @(posedge clk or negedge arst_n) begin : req_driver
		eau_op_t bus_op;
		eau_op_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				bus_op.act  = eau_pkg::action_t'(req_ch.action);
				bus_op.mode = req_ch.mode;
				bus_op.rf   = req_ch.reg_field;
				bus_op.sz   = req_ch.size_bytes;
				bus_op.ext  = req_ch.extension;
				bus_op.wval = req_ch.write_value;
				bus_op.hold = 1'b0;
				ea_results_due.push_back(compute_ea(bus_op));
				ops_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (operand_queue.size() != 0 &&
					!(operand_queue[0].hold && ea_results_due.size() != 0) &&
					$urandom_range(0, 99) >= sender_idle_pct()) begin
					nxt = operand_queue.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.action      <= nxt.act;
					req_ch.mode        <= nxt.mode;
					req_ch.reg_field   <= nxt.rf;
					req_ch.size_bytes  <= nxt.sz;
					req_ch.extension   <= nxt.ext;
					req_ch.write_value <= nxt.wval;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		eau_result_t exp_r;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (ea_results_due.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: unexpected result beat st=%0d val=%h pc=%h words=%0d",
							$realtime, rsp_ch.status, rsp_ch.ea_value, rsp_ch.pc_after,
							rsp_ch.ext_words_used);
				end else begin
					exp_r = ea_results_due.pop_front();
					case (exp_r.st)
						eau_pkg::ST_MEMORY:   n_mem++;
						eau_pkg::ST_REGISTER: n_regop++;
						eau_pkg::ST_ADDR_ERR: n_aerr++;
						default:              n_wr++;
					endcase
					if (rsp_ch.status !== exp_r.st || rsp_ch.ea_value !== exp_r.val ||
						rsp_ch.pc_after !== exp_r.pc || rsp_ch.ext_words_used !== exp_r.words) begin
						n_errors++;
						if (n_errors <= MAX_REPORTS)
							$display({"%0t: result %0d exp st=%0d val=%h pc=%h words=%0d",
								" got st=%0d val=%h pc=%h words=%0d"},
								$realtime, results_seen, exp_r.st, exp_r.val, exp_r.pc, exp_r.words,
								rsp_ch.status, rsp_ch.ea_value, rsp_ch.pc_after,
								rsp_ch.ext_words_used);
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		eau_op_t op;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = eau_pkg::ACT_EA;
		req_ch.mode        = eau_pkg::MODE_DREG;
		req_ch.reg_field   = 3'd0;
		req_ch.size_bytes  = 3'd0;
		req_ch.extension   = '0;
		req_ch.write_value = '0;
		rsp_ch.ready       = 1'b0;
		a_set        = '0;
		d_set        = '0;
		ops_accepted = 0;
		results_seen = 0;
		n_errors     = 0;
		n_mem        = 0;
		n_regop      = 0;
		n_aerr       = 0;
		n_wr         = 0;
		quiet_cycles = 0;
		prog_ctr     = '0;
		for (int i = 0; i < 8; i++) begin
			areg[i] = '0;
			dreg[i] = '0;
		end

		// Directed: register direct masks, stepping, wrap, every mode 7 form, odd PC
		queue_op(mk_op(eau_pkg::ACT_WR_DREG, eau_pkg::MODE_DREG, 3'd0, 3'd0, '0,
			eau_pkg::ALL_ONES));
		queue_op(mk_op(eau_pkg::ACT_WR_AREG, eau_pkg::MODE_DREG, eau_pkg::SP_REG, 3'd0, '0,
			32'h8000_0000));
		queue_op(mk_op(eau_pkg::ACT_WR_AREG, eau_pkg::MODE_DREG, 3'd2, 3'd0, '0,
			eau_pkg::ALL_ONES));
		queue_op(mk_op(eau_pkg::ACT_WR_AREG, eau_pkg::MODE_DREG, 3'd0, 3'd0, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_WR_DREG, eau_pkg::MODE_DREG, 3'd7, 3'd0, '0,
			32'h0001_8000));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_DREG, 3'd0, eau_pkg::SIZE_BYTE, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_DREG, 3'd0, 3'd0, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_AREG, eau_pkg::SP_REG,
			eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_AREG, eau_pkg::SP_REG, 3'd3, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_POSTINC, eau_pkg::SP_REG,
			eau_pkg::SIZE_BYTE, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_POSTINC, 3'd2, eau_pkg::SIZE_BYTE,
			'0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_PREDEC, 3'd0, eau_pkg::SIZE_LONG,
			'0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_PREDEC, eau_pkg::SP_REG,
			eau_pkg::SIZE_BYTE, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_IND, 3'd2, 3'd0, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_DISP, 3'd0, eau_pkg::SIZE_WORD,
			32'h0000_8000, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_DISP, 3'd0, eau_pkg::SIZE_WORD,
			32'hFFFF_7FFF, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_INDEX, eau_pkg::SP_REG,
			eau_pkg::SIZE_LONG, 32'h0000_8880, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_INDEX, 3'd2, eau_pkg::SIZE_BYTE,
			32'h0000_707F, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_ABS_W,
			eau_pkg::SIZE_WORD, 32'h1234_8000, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_ABS_L,
			eau_pkg::SIZE_LONG, eau_pkg::ALL_ONES, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_PC_DISP,
			eau_pkg::SIZE_WORD, 32'h0000_FFFE, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_PC_INDEX,
			eau_pkg::SIZE_WORD, 32'h0000_F8FF, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_IMM,
			eau_pkg::SIZE_BYTE, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_IMM,
			eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_IMM,
			eau_pkg::SIZE_LONG, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_IMM, 3'd0, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, 3'd5, eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, 3'd6, eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, 3'd7, eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_SET_PC, eau_pkg::MODE_EXT, 3'd7, 3'd7, eau_pkg::ALL_ONES,
			32'h0000_0001));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_DISP, 3'd0, eau_pkg::SIZE_WORD,
			32'h0000_0010, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_IMM,
			eau_pkg::SIZE_WORD, '0, '0));
		queue_op(mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_ABS_L,
			eau_pkg::SIZE_LONG, 32'h0000_1000, '0));
		queue_op(mk_op(eau_pkg::ACT_SET_PC, eau_pkg::MODE_DREG, 3'd0, 3'd0, '0,
			32'hFFFF_FFFE));
		op = mk_op(eau_pkg::ACT_EA, eau_pkg::MODE_EXT, eau_pkg::EXT_ABS_L, eau_pkg::SIZE_LONG,
			32'h00FF_0000, '0);
		op.hold = 1'b1;
		queue_op(op);

		// Random: mostly address computations, with writes and PC loads mixed in
		for (int i = 0; i < RANDOM_OPS; i++) begin
			op = rand_op();
			if (i % 120 == 60)
				op.hold = 1'b1;
			queue_op(op);
		end
		total_ops = operand_queue.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (operand_queue.size() != 0 || req_ch.valid || ea_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d operations: %0d memory addresses, %0d register operands,",
			ops_accepted, n_mem, n_regop);
		$display("  %0d odd-PC address errors and %0d register/PC writes; %0d mismatches",
			n_aerr, n_wr, n_errors);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
